// ===== src/atan2dr_pkg.sv =====
// shared types and constants for the rational atan2 core
`default_nettype none

package atan2dr_pkg;

  // input sample width and result width
  localparam int IN_BITS            = 16;
  localparam int ANGLE_BITS         = 17;
  localparam int FRAC_BITS_DEFAULT  = 8;

  // magnitudes at or above 2^MAG_LIMIT_BITS are scaled down before the ratio
  localparam int MAG_LIMIT_BITS     = 29;
  localparam int MAG_BITS           = (IN_BITS > MAG_LIMIT_BITS) ? MAG_LIMIT_BITS : IN_BITS;
  localparam int PROD_BITS          = 2 * MAG_BITS;
  // denominator of the ratio is at most 16 times the square of the larger magnitude
  localparam int SUM_BITS           = PROD_BITS + 4;

  // entries between front and back
  localparam int QUEUE_DEPTH        = 4;

  typedef struct packed {
    logic signed [IN_BITS-1:0] numerator;
    logic signed [IN_BITS-1:0] denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [ANGLE_BITS-1:0] angle;
    logic                         undefined;
  } out_item_t;

  // quadrant and special case flags
  typedef struct packed {
    logic num_neg;
    logic den_neg;
    logic den_zero;
    logic both_zero;
  } quad_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [MAG_BITS-1:0] mag_n;
    logic [MAG_BITS-1:0] mag_d;
    quad_t               quad;
  } work_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== src/atan2_degrees_rational_core.sv =====
// top level of the rational-approximation atan2 core, result in degrees
//
// Usage:
//   in_valid/in_stall/in_data carry (numerator, denominator) pairs; a
//   transfer happens at a rising edge with valid high and stall low.
//   out_valid/out_stall/out_data carry (angle, undefined); angle is
//   degrees in signed fixed point with FRAC_BITS fraction bits.
//   One result per input, in input order.
// Pipeline: front register, queue, product stage, ratio term stage,
//   7 + FRAC_BITS division stages, output register.
// Throughput: one item per cycle while no result is held; the division is
//   unrolled into one stage per bit of the 90 degree constant.
// Stall: a held result freezes the back pipeline; the front keeps taking
//   items until the front register and the four-entry queue are full,
//   then raises in_stall.
// Reset: synchronous; rst_n low empties the front register, queue and
//   pipeline; no result is pending afterwards.
`default_nettype none

module atan2_degrees_rational_core #(
  parameter int FRAC_BITS = atan2dr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  atan2dr_pkg::in_item_t  in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output atan2dr_pkg::out_item_t out_data
);
  import atan2dr_pkg::*;

  logic        push;
  logic        pop;
  work_item_t  push_item;
  work_item_t  head;
  queue_stat_t q_stat;

  // classify and scale
  atan2dr_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .push      (push),
    .push_item (push_item),
    .q_stat    (q_stat)
  );

  // decoupling queue
  atan2dr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .stat      (q_stat)
  );

  // arithmetic pipeline
  atan2dr_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== src/atan2dr_front.sv =====
// front stage: takes input transfers, forms magnitudes and quadrant flags
`default_nettype none

module atan2dr_front (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  atan2dr_pkg::in_item_t    in_data,
  output logic                     push,
  output atan2dr_pkg::work_item_t  push_item,
  input  atan2dr_pkg::queue_stat_t q_stat
);
  import atan2dr_pkg::*;

  logic               fv_r;
  logic               fv_nxt;
  work_item_t         item_r;
  work_item_t         item_nxt;
  logic               accept;
  logic [IN_BITS-1:0] raw_n;
  logic [IN_BITS-1:0] raw_d;
  logic [IN_BITS-1:0] abs_n;
  logic [IN_BITS-1:0] abs_d;
  logic [IN_BITS-1:0] sh_n;
  logic [IN_BITS-1:0] sh_d;

  // handshake: hold the input while the front register cannot drain
  assign in_stall  = fv_r & q_stat.full;
  assign accept    = in_valid & ~in_stall;
  assign push      = fv_r & ~q_stat.full;
  assign push_item = item_r;
  assign fv_nxt    = accept | (fv_r & ~push);

  // magnitudes, joint scaling of very large values, quadrant flags
  always_comb begin
    raw_n = in_data.numerator;
    raw_d = in_data.denominator;
    abs_n = raw_n[IN_BITS-1] ? (~raw_n + 1'b1) : raw_n;
    abs_d = raw_d[IN_BITS-1] ? (~raw_d + 1'b1) : raw_d;
    sh_n  = abs_n;
    sh_d  = abs_d;
    for (int i = 0; i < IN_BITS - MAG_LIMIT_BITS; i++) begin
      if (((sh_n | sh_d) >> MAG_LIMIT_BITS) != '0) begin
        sh_n = sh_n >> 1;
        sh_d = sh_d >> 1;
      end
    end
    item_nxt.mag_n          = sh_n[MAG_BITS-1:0];
    item_nxt.mag_d          = sh_d[MAG_BITS-1:0];
    item_nxt.quad.num_neg   = raw_n[IN_BITS-1];
    item_nxt.quad.den_neg   = raw_d[IN_BITS-1];
    item_nxt.quad.den_zero  = (raw_d == '0);
    item_nxt.quad.both_zero = (raw_n == '0) && (raw_d == '0);
  end

  // front register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
    if (accept) begin
      item_r <= item_nxt;
    end
  end

`ifndef SYNTHESIS
  // a new item only lands on a held one when the held one leaves
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && fv_r) |-> push)
    else $error("front register overwritten");
`endif

endmodule

`default_nettype wire

// ===== src/atan2dr_queue.sv =====
// short queue between the front and back stages
`default_nettype none

module atan2dr_queue (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  atan2dr_pkg::work_item_t  push_item,
  input  logic                     pop,
  output atan2dr_pkg::work_item_t  head,
  output atan2dr_pkg::queue_stat_t stat
);
  import atan2dr_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  work_item_t       entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  assign stat.full  = (cnt_r == CNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign head       = entry_r[rd_ptr_r];

  // pointer and fill count updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // storage and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !stat.full)
    else $error("push into full queue");

  a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(QUEUE_DEPTH))
    else $error("queue fill count out of range");
`endif

endmodule

`default_nettype wire

// ===== src/atan2dr_back.sv =====
// back stages: products, ratio terms, pipelined scaled division, quadrant fixup
`default_nettype none

module atan2dr_back #(
  parameter int FRAC_BITS = atan2dr_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst_n,
  output logic                     pop,
  input  atan2dr_pkg::work_item_t  head,
  input  atan2dr_pkg::queue_stat_t q_stat,
  output logic                     out_valid,
  input  logic                     out_stall,
  output atan2dr_pkg::out_item_t   out_data
);
  import atan2dr_pkg::*;

  // 90 degrees in output units; its bits drive the division stages
  localparam int             UB     = 7 + FRAC_BITS;
  localparam logic [UB-1:0]  UNIT90 = {7'd90, {FRAC_BITS{1'b0}}};
  localparam int             REM_W  = SUM_BITS + 2;

  logic                 en;

  // product stage
  logic                 mv_r;
  quad_t                mquad_r;
  logic [PROD_BITS-1:0] aa_r;
  logic [PROD_BITS-1:0] ab_r;
  logic [PROD_BITS-1:0] bb_r;
  logic [PROD_BITS-1:0] aa_nxt;
  logic [PROD_BITS-1:0] ab_nxt;
  logic [PROD_BITS-1:0] bb_nxt;

  // division pipeline, index 0 holds the ratio terms
  logic                 dv_r    [0:UB];
  quad_t                dquad_r [0:UB];
  logic [SUM_BITS-1:0]  dnum_r  [0:UB];
  logic [SUM_BITS-1:0]  dden_r  [0:UB];
  logic [SUM_BITS-1:0]  drem_r  [0:UB];
  logic [UB-1:0]        dq_r    [0:UB];
  logic [SUM_BITS-1:0]  num_nxt;
  logic [SUM_BITS-1:0]  den_nxt;

  // final stage
  logic                 round_up;
  logic [UB-1:0]        t_val;
  logic [UB:0]          mag;
  logic [ANGLE_BITS-1:0] mag_a;
  logic                 out_valid_r;
  out_item_t            out_item_r;
  out_item_t            out_item_nxt;

  // whole back pipeline advances unless a finished result is held
  assign en        = ~out_valid_r | ~out_stall;
  assign pop       = en & ~q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // squares and cross product of the magnitudes
  always_comb begin
    aa_nxt = head.mag_n * head.mag_n;
    ab_nxt = head.mag_n * head.mag_d;
    bb_nxt = head.mag_d * head.mag_d;
  end

  // num = 3ab + 5a^2, den = 5b^2 + 6ab + 5a^2
  always_comb begin
    num_nxt = (SUM_BITS'(ab_r) << 1) + SUM_BITS'(ab_r)
            + (SUM_BITS'(aa_r) << 2) + SUM_BITS'(aa_r);
    den_nxt = (SUM_BITS'(bb_r) << 2) + SUM_BITS'(bb_r)
            + (SUM_BITS'(ab_r) << 2) + (SUM_BITS'(ab_r) << 1)
            + (SUM_BITS'(aa_r) << 2) + SUM_BITS'(aa_r);
  end

  // product and ratio term registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r  <= 1'b0;
      dv_r[0] <= 1'b0;
    end else if (en) begin
      mv_r  <= ~q_stat.empty;
      dv_r[0] <= mv_r;
    end
    if (en) begin
      mquad_r    <= head.quad;
      aa_r       <= aa_nxt;
      ab_r       <= ab_nxt;
      bb_r       <= bb_nxt;
      dquad_r[0] <= mquad_r;
      dnum_r[0]  <= num_nxt;
      dden_r[0]  <= den_nxt;
      drem_r[0]  <= '0;
      dq_r[0]    <= '0;
    end
  end

  // one bit of 90 degrees per stage, quotient digit 0, 1 or 2
  for (genvar k = 0; k < UB; k++) begin : g_div
    logic [REM_W-1:0]    den1;
    logic [REM_W-1:0]    den2;
    logic [REM_W-1:0]    trial;
    logic [REM_W-1:0]    rem_w;
    logic [1:0]          digit;
    logic [SUM_BITS-1:0] rem_nxt;
    logic [UB-1:0]       q_nxt;

    always_comb begin
      den1  = REM_W'(dden_r[k]);
      den2  = den1 << 1;
      trial = (REM_W'(drem_r[k]) << 1)
            + (UNIT90[UB-1-k] ? REM_W'(dnum_r[k]) : '0);
      if (trial >= den2) begin
        rem_w = trial - den2;
        digit = 2'd2;
      end else if (trial >= den1) begin
        rem_w = trial - den1;
        digit = 2'd1;
      end else begin
        rem_w = trial;
        digit = 2'd0;
      end
      rem_nxt = rem_w[SUM_BITS-1:0];
      q_nxt   = (dq_r[k] << 1) + UB'(digit);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (en) begin
        dv_r[k+1] <= dv_r[k];
      end
      if (en) begin
        dquad_r[k+1] <= dquad_r[k];
        dnum_r[k+1]  <= dnum_r[k];
        dden_r[k+1]  <= dden_r[k];
        drem_r[k+1]  <= rem_nxt;
        dq_r[k+1]    <= q_nxt;
      end
    end
  end

  // round half up, then quadrant rules and special cases
  always_comb begin
    round_up = ((REM_W'(drem_r[UB]) << 1) >= REM_W'(dden_r[UB]));
    t_val    = dq_r[UB] + UB'(round_up);
    if (dquad_r[UB].den_zero) begin
      mag = {1'b0, UNIT90};
    end else if (dquad_r[UB].den_neg) begin
      mag = {UNIT90, 1'b0} - {1'b0, t_val};
    end else begin
      mag = {1'b0, t_val};
    end
    mag_a = ANGLE_BITS'(mag);
    if (dquad_r[UB].both_zero) begin
      out_item_nxt.angle     = '0;
      out_item_nxt.undefined = 1'b1;
    end else begin
      out_item_nxt.angle     = dquad_r[UB].num_neg ? -mag_a : mag_a;
      out_item_nxt.undefined = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_r[UB];
    end
    if (en) begin
      out_item_r <= out_item_nxt;
    end
  end

`ifndef SYNTHESIS
  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.undefined) |-> (out_item_r.angle == '0))
    else $error("undefined result with nonzero angle");

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[UB] && !dquad_r[UB].both_zero) |-> (drem_r[UB] < dden_r[UB]))
    else $error("division remainder not below divisor");
`endif

endmodule

`default_nettype wire
